// ===== rtl/sscd_pkg.sv =====
// Shared types, constants and functions of the seven-segment chain driver.
`default_nettype none

package sscd_pkg;

  localparam int unsigned MAX_CHAIN_DEF = 32;
  localparam int unsigned CHAIN_CAP     = 32;

  localparam logic [3:0] TABLE_LAST = 4'd10;

  localparam logic [7:0] ANODE_TAB [11] = '{
    8'h80, 8'hF2, 8'h48, 8'h60, 8'h32, 8'h24, 8'h04, 8'hF0, 8'h00, 8'h20, 8'h00
  };
  localparam logic [7:0] CATHODE_TAB [11] = '{
    8'h7F, 8'h0D, 8'hB7, 8'h9F, 8'hCD, 8'hDB, 8'hFB, 8'h0F, 8'hFF, 8'hDF, 8'hFF
  };

  typedef enum logic [1:0] {
    REQ_TIME  = 2'd0,
    REQ_DIGIT = 2'd1,
    REQ_DOT   = 2'd2,
    REQ_ALL   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_COMMON_ANODE = 3'd0,
    CFG_CHAIN_LENGTH = 3'd1,
    CFG_TIME_ORDER   = 3'd2,
    CFG_TIME_START   = 3'd3,
    CFG_COLON_POS    = 3'd4
  } cfg_idx_e;

  // Sequencer step addresses.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_TCHK = 3'd1,
    ST_TDIG = 3'd2,
    ST_TDOT = 3'd3,
    ST_EMIT = 3'd4,
    ST_DIG  = 3'd5,
    ST_DOT  = 3'd6,
    ST_ALL  = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_NOP,
    OP_TDIG,
    OP_DOT,
    OP_DIG,
    OP_ALL,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_DISPATCH,
    CND_SHORT,
    CND_MORE,
    CND_REJECT,
    CND_DONE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e alt;
    step_e nxt;
  } ucw_t;

  // Write request into the frame store.
  typedef struct packed {
    logic       en;
    logic       dot_only;
    logic [4:0] addr;
    logic [7:0] data;
  } store_wr_t;

  // Control program: one word per step.
  function automatic ucw_t ucode(input step_e st);
    ucw_t w;
    case (st)
      ST_IDLE: w = '{op: OP_IDLE, cond: CND_DISPATCH, alt: ST_IDLE, nxt: ST_IDLE};
      ST_TCHK: w = '{op: OP_NOP,  cond: CND_SHORT,    alt: ST_IDLE, nxt: ST_TDIG};
      ST_TDIG: w = '{op: OP_TDIG, cond: CND_MORE,     alt: ST_TDIG, nxt: ST_TDOT};
      ST_TDOT: w = '{op: OP_DOT,  cond: CND_NONE,     alt: ST_IDLE, nxt: ST_EMIT};
      ST_EMIT: w = '{op: OP_EMIT, cond: CND_DONE,     alt: ST_IDLE, nxt: ST_EMIT};
      ST_DIG:  w = '{op: OP_DIG,  cond: CND_REJECT,   alt: ST_IDLE, nxt: ST_EMIT};
      ST_DOT:  w = '{op: OP_DOT,  cond: CND_NONE,     alt: ST_IDLE, nxt: ST_IDLE};
      ST_ALL:  w = '{op: OP_ALL,  cond: CND_NONE,     alt: ST_IDLE, nxt: ST_EMIT};
      default: w = '{op: OP_IDLE, cond: CND_DISPATCH, alt: ST_IDLE, nxt: ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_e dispatch(input logic [1:0] req);
    step_e s;
    case (req)
      REQ_TIME:  s = ST_TCHK;
      REQ_DIGIT: s = ST_DIG;
      REQ_DOT:   s = ST_DOT;
      REQ_ALL:   s = ST_ALL;
      default:   s = ST_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] pattern(input logic [3:0] idx, input logic anode);
    logic [3:0] i;
    i = (idx > TABLE_LAST) ? TABLE_LAST : idx;
    return anode ? ANODE_TAB[i] : CATHODE_TAB[i];
  endfunction

  // Divide by ten through a reciprocal, exact for 7-bit values.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] r;
    r = v - 7'({3'b000, t}) * 7'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sscd_in_if.sv =====
// Request channel of the seven-segment chain driver.
`default_nettype none

interface sscd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] hours;
  logic [6:0] minutes;
  logic [6:0] seconds;
  logic       colon_on;
  logic [7:0] position;
  logic [3:0] digit_code;
  logic       dot_on;

  modport source (
    output valid, req_type, hours, minutes, seconds, colon_on, position, digit_code,
           dot_on,
    input  ready
  );
  modport sink (
    input  valid, req_type, hours, minutes, seconds, colon_on, position, digit_code,
           dot_on,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/sscd_out_if.sv =====
// Frame byte channel of the seven-segment chain driver.
`default_nettype none

interface sscd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] chain_index;
  logic       latch;

  modport source (
    output valid, frame_byte, chain_index, latch,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, chain_index, latch,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/sscd_store.sv =====
// Frame store: one segment byte per chain register, with dot-only writes.
`default_nettype none

module sscd_store import sscd_pkg::*; #(
  parameter int unsigned DEPTH = CHAIN_CAP,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  store_wr_t     wr_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0]    mem_q [DEPTH];
  logic [AW-1:0] wa;

  assign wa        = wr_i.addr[AW-1:0];
  assign rd_data_o = mem_q[rd_addr_i];

  // Reset blanks every digit (all ones).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem_q[i] <= 8'hFF;
      end
    end else if (wr_i.en) begin
      if (wr_i.dot_only) begin
        mem_q[wa][0] <= wr_i.data[0];
      end else begin
        mem_q[wa] <= wr_i.data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/seven_segment_chain_driver.sv =====
// Top level: microcoded driver for a chain of seven-segment shift registers.
//
//   channel   dir  handshake                 payload
//   req_i     in   valid/ready               req_type hours minutes seconds colon_on
//                                            position digit_code dot_on
//   frame_o   out  valid/ready               frame_byte chain_index latch
//   cfg       in   cfg_we_i (no back-press)  cfg_idx_i, cfg_data_i
//
// The frame readout moves the active chain out of the store, one byte per
// cycle; a stalled sink stops it.
// Reset blanks the store at once (no clearing pass) and loads the register
// defaults. req_i.ready is high only in the idle step; the last byte may
// still wait in the output register while the next item is taken.
`default_nettype none

module seven_segment_chain_driver import sscd_pkg::*; #(
  parameter int unsigned MAX_CHAIN = MAX_CHAIN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  sscd_in_if.sink    req_i,
  sscd_out_if.source frame_o
);

  // Only positions below 32 can ever be in use.
  localparam int unsigned DEPTH = (MAX_CHAIN < CHAIN_CAP) ? MAX_CHAIN : CHAIN_CAP;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [5:0]  NMAX  = 6'(DEPTH);

  // Configuration registers.
  logic       anode_q;
  logic [5:0] chain_len_q;
  logic [1:0] order_q;
  logic [4:0] tstart_q;
  logic [4:0] colon_pos_q;

  // Captured item.
  logic [1:0] req_q;
  logic [6:0] hrs_q, min_q, sec_q;
  logic       colon_on_q;
  logic [7:0] pos_q;
  logic [3:0] code_q;
  logic       dot_q;

  // Sequencer.
  step_e      step_q, step_d;
  ucw_t       uc;
  logic [2:0] k_q, k_d;
  logic [4:0] cnt_q, cnt_d;
  logic       hit;

  // Output register.
  logic       ov_q;
  logic [7:0] fb_q;
  logic [4:0] ci_q;
  logic       lt_q;

  logic       acc;
  logic [5:0] n_eff;
  store_wr_t  wr;
  logic [7:0] rd_data;

  // Datapath terms.
  logic [6:0] tval;
  logic [3:0] tens, ones, tdig;
  logic [5:0] tpos;
  logic [7:0] dpos;
  logic       don, dot_in, set_bit;
  logic       dig_ok, all_one, fill;
  logic [7:0] lit, pm1;
  logic       out_load, done;

  assign uc    = ucode(step_q);
  assign acc   = req_i.valid && req_i.ready;
  assign n_eff = (chain_len_q > NMAX) ? NMAX : chain_len_q;
  assign req_i.ready = (uc.op == OP_IDLE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anode_q     <= 1'b1;
      chain_len_q <= 6'd8;
      order_q     <= 2'd1;
      tstart_q    <= 5'd0;
      colon_pos_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COMMON_ANODE: anode_q     <= cfg_data_i[0];
        CFG_CHAIN_LENGTH: chain_len_q <= cfg_data_i;
        CFG_TIME_ORDER:   order_q     <= cfg_data_i[1:0];
        CFG_TIME_START:   tstart_q    <= cfg_data_i[4:0];
        CFG_COLON_POS:    colon_pos_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // ---------------- capture the item ----------------
  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q      <= req_i.req_type;
      hrs_q      <= req_i.hours;
      min_q      <= req_i.minutes;
      sec_q      <= req_i.seconds;
      colon_on_q <= req_i.colon_on;
      pos_q      <= req_i.position;
      code_q     <= req_i.digit_code;
      dot_q      <= req_i.dot_on;
    end
  end

  // ---------------- datapath terms ----------------
  always_comb begin
    // Order bit 0 puts hours first, order bit 1 puts the ones digit first.
    case (k_q[2:1])
      2'd0:    tval = order_q[0] ? hrs_q : sec_q;
      2'd1:    tval = min_q;
      default: tval = order_q[0] ? sec_q : hrs_q;
    endcase
    tens = tens_of(tval);
    ones = ones_of(tval, tens);
    tdig = (order_q[1] ^ k_q[0]) ? ones : tens;
    tpos = {1'b0, tstart_q} + {3'b000, k_q};

    // Colon in time mode, addressed dot otherwise.
    dpos    = (req_q == REQ_TIME) ? {3'b000, colon_pos_q} : pos_q;
    don     = (req_q == REQ_TIME) ? colon_on_q : dot_q;
    dot_in  = (dpos < {2'b00, n_eff});
    set_bit = anode_q ? !don : don;

    dig_ok  = (pos_q < {2'b00, n_eff}) && (code_q <= TABLE_LAST);
    lit     = anode_q ? 8'h00 : 8'hFF;
    pm1     = pos_q - 8'd1;
    all_one = (pos_q != 8'd0) && (pos_q <= {2'b00, n_eff});
    // All on with position zero lights each byte as it is read out.
    fill    = (req_q == REQ_ALL) && (pos_q == 8'd0);

    out_load = (uc.op == OP_EMIT) && (n_eff != 6'd0) && (!ov_q || frame_o.ready);
    done     = (n_eff == 6'd0) || (out_load && (cnt_q == 5'd0));
  end

  // ---------------- store write per step ----------------
  always_comb begin
    wr = '0;
    case (uc.op)
      OP_TDIG: begin
        wr.en   = (tpos < n_eff);
        wr.addr = tpos[4:0];
        wr.data = pattern(tdig, anode_q);
      end
      OP_DOT: begin
        wr.en       = dot_in;
        wr.dot_only = 1'b1;
        wr.addr     = dpos[4:0];
        wr.data     = {7'd0, set_bit};
      end
      OP_DIG: begin
        wr.en   = dig_ok;
        wr.addr = pos_q[4:0];
        wr.data = pattern(code_q, anode_q);
      end
      OP_ALL: begin
        wr.en   = all_one;
        wr.addr = pm1[4:0];
        wr.data = lit;
      end
      OP_EMIT: begin
        wr.en   = out_load && fill;
        wr.addr = cnt_q;
        wr.data = lit;
      end
      default: wr = '0;
    endcase
  end

  sscd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (cnt_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    case (uc.cond)
      CND_SHORT:  hit = (n_eff < 6'd6);
      CND_MORE:   hit = (k_q != 3'd5);
      CND_REJECT: hit = !dig_ok;
      CND_DONE:   hit = done;
      default:    hit = 1'b0;
    endcase

    if (uc.cond == CND_DISPATCH) begin
      step_d = acc ? dispatch(req_i.req_type) : uc.nxt;
    end else begin
      step_d = hit ? uc.alt : uc.nxt;
    end

    k_d   = k_q;
    cnt_d = cnt_q;
    if (acc) begin
      k_d   = 3'd0;
      cnt_d = 5'(n_eff - 6'd1);
    end else if (uc.op == OP_TDIG) begin
      k_d = k_q + 3'd1;
    end else if (out_load) begin
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      k_q    <= 3'd0;
      cnt_q  <= 5'd0;
    end else begin
      step_q <= step_d;
      k_q    <= k_d;
      cnt_q  <= cnt_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (frame_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fb_q <= fill ? lit : rd_data;
      ci_q <= cnt_q;
      lt_q <= (cnt_q == 5'd0);
    end
  end

  assign frame_o.valid       = ov_q;
  assign frame_o.frame_byte  = fb_q;
  assign frame_o.chain_index = ci_q;
  assign frame_o.latch       = lt_q;

  // ---------------- assertions ----------------
  a_latch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid |-> (frame_o.latch == (frame_o.chain_index == 5'd0)))
    else $error("latch flag not on position zero");

  a_emit_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ({1'b0, cnt_q} < n_eff))
    else $error("readout index beyond the active chain");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !req_i.ready)
    else $error("request taken twice without work");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_TDIG) |-> (k_q < 3'd6))
    else $error("time digit counter overrun");

endmodule

`default_nettype wire
